// ----- src/rau_pkg.sv -----
// Package for the rational arithmetic unit: opcodes, status codes, widths.
package rau_pkg;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam logic [2:0] OP_NORM = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_NEG  = 3'd5;
  localparam logic [2:0] OP_ABS  = 3'd6;
  localparam logic [2:0] OP_CMP  = 3'd7;
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;
  localparam logic [1:0] CMP_LT  = 2'd0;
  localparam logic [1:0] CMP_EQ  = 2'd1;
  localparam logic [1:0] CMP_GT  = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture operands, form cross products
    logic combine;   // form numerator/denominator magnitudes
    logic gcd_init;  // seed the gcd registers
    logic gcd_step;  // one restoring-division bit step
    logic rem_done;  // commit remainder, swap a/b
    logic div_init;  // seed the reduce division
    logic div_step;  // one quotient bit for both divisions
    logic finish;    // form the result word
  } rau_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic b_zero;    // gcd divisor reached zero
    logic cnt_done;  // bit counter at its end
    logic early;     // result settled without reduction
  } rau_stat_t;
endpackage

// ----- src/rau_ctrl.sv -----
// Controller state machine for the rational arithmetic unit.
module rau_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rau_pkg::rau_cmd_t   cmd,
  input  rau_pkg::rau_stat_t  stat
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMB = 3'd1;
  localparam logic [2:0] S_GINI = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_COMB;
      end
      S_COMB: begin
        cmd.combine = 1'b1;
        state_next = S_GINI;
      end
      S_GINI: begin
        if (stat.early) begin
          state_next = S_FIN;
        end else begin
          cmd.gcd_init = 1'b1;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.b_zero) begin
          cmd.div_init = 1'b1;
          state_next = S_DIV;
        end else if (stat.cnt_done) begin
          cmd.rem_done = 1'b1;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.cnt_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("in_ready and out_valid both high");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  a_load_idle: assert property (@(posedge clk) disable iff (rst) cmd.load |-> in_ready)
    else $error("load outside idle");
endmodule

// ----- src/rau_dp.sv -----
// Datapath for the rational arithmetic unit: products, gcd and reduction.
module rau_dp #(
  parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic [2:0]         op,
  input  logic [31:0]        lhs_num,
  input  logic [31:0]        lhs_den,
  input  logic [31:0]        rhs_num,
  input  logic [31:0]        rhs_den,
  input  rau_pkg::rau_cmd_t  cmd,
  output rau_pkg::rau_stat_t stat,
  output logic [31:0]        res_num,
  output logic [30:0]        res_den,
  output logic [1:0]         cmp_result,
  output logic [1:0]         status
);
  localparam int MW = 2 * VALUE_WIDTH;
  localparam int CW = $clog2(MW + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(MW - 1);

  logic [VALUE_WIDTH-1:0] an_v, ad_v, bn_v, bd_v;
  logic [VALUE_WIDTH:0]   am_x, ad_x, bm_x, bd_x;
  logic                   a_neg, b_neg, a_dz, b_dz, b_mz, uses_rhs;

  assign an_v = lhs_num[VALUE_WIDTH-1:0];
  assign ad_v = lhs_den[VALUE_WIDTH-1:0];
  assign bn_v = rhs_num[VALUE_WIDTH-1:0];
  assign bd_v = rhs_den[VALUE_WIDTH-1:0];

  function automatic logic [VALUE_WIDTH:0] mag_of(input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH:0] e;
    e = {v[VALUE_WIDTH-1], v};
    return v[VALUE_WIDTH-1] ? (~e + 1'b1) : e;
  endfunction

  assign am_x = mag_of(an_v);
  assign ad_x = mag_of(ad_v);
  assign bm_x = mag_of(bn_v);
  assign bd_x = mag_of(bd_v);
  assign a_neg = (am_x != '0) && (an_v[VALUE_WIDTH-1] != ad_v[VALUE_WIDTH-1]);
  assign b_neg = (bm_x != '0) && (bn_v[VALUE_WIDTH-1] != bd_v[VALUE_WIDTH-1]);
  assign a_dz = (ad_x == '0);
  assign b_dz = (bd_x == '0);
  assign b_mz = (bm_x == '0);
  assign uses_rhs = (op == rau_pkg::OP_ADD) || (op == rau_pkg::OP_SUB) ||
                    (op == rau_pkg::OP_MUL) || (op == rau_pkg::OP_DIV) ||
                    (op == rau_pkg::OP_CMP);

  // stage 1 registers: lhs magnitudes, signs and four cross products
  logic [2:0]    op_r;
  logic          an_r, bn_r, zd_r;
  logic [MW-1:0] p_ab, p_ba, p_mm, p_dd, am_r, ad_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op;
      an_r <= a_neg;
      bn_r <= b_neg;
      zd_r <= a_dz || (uses_rhs && b_dz) || ((op == rau_pkg::OP_DIV) && b_mz);
      p_ab <= MW'(am_x) * MW'(bd_x);
      p_ba <= MW'(bm_x) * MW'(ad_x);
      p_mm <= MW'(am_x) * MW'(bm_x);
      p_dd <= MW'(ad_x) * MW'(bd_x);
      am_r <= MW'(am_x);
      ad_r <= MW'(ad_x);
    end
  end

  // stage 2: combine into magnitude, denominator and sign
  logic          bneg_e, same, ge;
  logic [MW:0]   sum;
  logic          rn_c;
  logic [MW-1:0] rm_c, rd_c;
  logic          r_neg;
  logic [MW-1:0] r_mag, r_den;
  logic [1:0]    cmp_r;

  assign bneg_e = (op_r == rau_pkg::OP_ADD) ? bn_r : !bn_r;
  assign same = (an_r == bneg_e);
  assign ge = (p_ab >= p_ba);
  assign sum = same ? ({1'b0, p_ab} + {1'b0, p_ba})
                    : (ge ? {1'b0, p_ab - p_ba} : {1'b0, p_ba - p_ab});

  always_comb begin
    rn_c = an_r;
    rm_c = am_r;
    rd_c = ad_r;
    case (op_r)
      rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_CMP: begin
        rn_c = (same || ge) ? an_r : bneg_e;
        rm_c = sum[MW-1:0];
        rd_c = p_dd;
      end
      rau_pkg::OP_MUL: begin
        rn_c = an_r != bn_r; rm_c = p_mm; rd_c = p_dd;
      end
      rau_pkg::OP_DIV: begin
        rn_c = an_r != bn_r; rm_c = p_ab; rd_c = p_ba;
      end
      rau_pkg::OP_NEG: rn_c = !an_r;
      rau_pkg::OP_ABS: rn_c = 1'b0;
      default: rn_c = an_r;
    endcase
    if (rm_c == '0) rn_c = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.combine) begin
      r_neg <= rn_c;
      r_mag <= rm_c;
      r_den <= rd_c;
      cmp_r <= (rm_c == '0) ? rau_pkg::CMP_EQ : (rn_c ? rau_pkg::CMP_LT : rau_pkg::CMP_GT);
    end
  end

  // shared restoring divider: remainder register, quotients, bit counter
  logic [MW-1:0] ga, gb, rem, q1, q2, r2, sh1;
  logic [CW-1:0] cnt;
  logic [MW:0]   t1, t2;

  assign t1 = {rem, (cmd.div_step ? q1[MW-1] : ga[MW-1])} - {1'b0, gb};
  assign t2 = {r2, q2[MW-1]} - {1'b0, gb};
  assign sh1 = {rem[MW-2:0], (cmd.div_step ? q1[MW-1] : ga[MW-1])};

  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      ga <= r_mag; gb <= r_den; rem <= '0; cnt <= '0;
    end else if (cmd.gcd_step) begin
      ga  <= {ga[MW-2:0], 1'b0};
      rem <= t1[MW] ? sh1 : t1[MW-1:0];
      cnt <= cnt + 1'b1;
    end else if (cmd.rem_done) begin
      // last bit step lands straight in the new divisor
      ga  <= gb;
      gb  <= t1[MW] ? sh1 : t1[MW-1:0];
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_init) begin
      gb <= ga;   // gcd
      q1 <= r_mag; q2 <= r_den; rem <= '0; r2 <= '0; cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= t1[MW] ? sh1 : t1[MW-1:0];
      q1  <= {q1[MW-2:0], ~t1[MW]};
      r2  <= t2[MW] ? {r2[MW-2:0], q2[MW-1]} : t2[MW-1:0];
      q2  <= {q2[MW-2:0], ~t2[MW]};
      cnt <= cnt + 1'b1;
    end
  end

  // final checks and result word
  localparam logic [MW-1:0] LIM = MW'(1) << (VALUE_WIDTH - 1);
  logic       ovf;
  logic [MW-1:0] sn;

  assign ovf = (q2 > LIM - 1'b1) || (q1 > (r_neg ? LIM : LIM - 1'b1));
  assign sn = r_neg ? (~q1 + 1'b1) : q1;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_num <= 32'd0; res_den <= 31'd1; cmp_result <= rau_pkg::CMP_LT;
      if (zd_r) begin
        status <= rau_pkg::ST_ZDEN;
      end else if (op_r == rau_pkg::OP_CMP) begin
        status <= rau_pkg::ST_OK; cmp_result <= cmp_r;
      end else if (ovf) begin
        status <= rau_pkg::ST_OVF;
      end else begin
        status <= rau_pkg::ST_OK;
        res_num <= 32'($signed(sn[VALUE_WIDTH-1:0]));
        res_den <= 31'(q2[VALUE_WIDTH-2:0]);
      end
    end
  end

  assign stat.b_zero = (gb == '0);
  assign stat.cnt_done = (cnt == CNT_LAST) || (cnt > CNT_LAST);
  assign stat.early = zd_r || (op_r == rau_pkg::OP_CMP);
endmodule

// ----- src/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit.
// Usage: one stream word in (s_axis), one stream word out (m_axis).
// s_axis_tdata carries op, lhs_num, lhs_den, rhs_num, rhs_den; m_axis_tdata
// carries res_num, res_den, cmp_result, status. A word is taken when tvalid
// and tready are both high.
// One word is worked on at a time. Compare and zero-denominator results
//   skip the gcd. Other ops find each Euclid remainder by a 2W-bit
//   division (W = VALUE_WIDTH) on the shared restoring divider, which then
//   divides num and den by the gcd.
// s_axis_tready returns the cycle after the result is taken.
// The result stays on m_axis until taken; s_axis_tready stays low meanwhile.
// Reset (rst, synchronous) returns the controller to idle and drops any
// pending result.
module rational_arithmetic_unit #(
  parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[2:0], lhs_num[34:3], lhs_den[66:35], rhs_num[98:67], rhs_den[130:99]
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_num[31:0], res_den[62:32], cmp_result[64:63], status[66:65]
  output logic [71:0]  m_axis_tdata
);
  rau_pkg::rau_cmd_t  cmd;
  rau_pkg::rau_stat_t stat;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic [1:0]  cmp_result, status;

  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd(cmd), .stat(stat)
  );

  rau_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk),
    .op(s_axis_tdata[2:0]),
    .lhs_num(s_axis_tdata[34:3]),
    .lhs_den(s_axis_tdata[66:35]),
    .rhs_num(s_axis_tdata[98:67]),
    .rhs_den(s_axis_tdata[130:99]),
    .cmd(cmd), .stat(stat),
    .res_num(res_num), .res_den(res_den),
    .cmp_result(cmp_result), .status(status)
  );

  assign m_axis_tdata = {5'd0, status, cmp_result, res_den, res_num};
endmodule

// ----- tb/sv/rau_checker.sv -----
`timescale 1ns / 1ps
// Stream monitor and result predictor for the rational arithmetic unit.
module rau_checker
  import rau_pkg::*;
#(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [71:0]  m_axis_tdata,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  cmp;
    logic [1:0]  status;
  } frac_word_t;

  typedef struct {
    logic        neg;
    logic [63:0] mag;
    logic [63:0] den;
  } sm_frac_t;

  frac_word_t expected_q[$];

  function automatic logic [63:0] sext_w(logic [31:0] x);
    logic [63:0] v;
    v = {{(64 - W){x[W - 1]}}, x[W - 1:0]};
    return v;
  endfunction

  function automatic sm_frac_t to_frac(logic [31:0] n_bits, logic [31:0] d_bits);
    sm_frac_t f;
    logic [63:0] n;
    logic [63:0] d;
    n = sext_w(n_bits);
    d = sext_w(d_bits);
    f.mag = n[63] ? -n : n;
    f.den = d[63] ? -d : d;
    f.neg = (f.mag != 0) && (n[63] != d[63]);
    return f;
  endfunction

  // a +/- b at double width, sign and magnitude
  function automatic sm_frac_t frac_sum(sm_frac_t a, sm_frac_t b, logic negate_b);
    sm_frac_t r;
    logic bn;
    logic [63:0] am;
    logic [63:0] bm;
    bn = negate_b ? !b.neg : b.neg;
    am = a.mag * b.den;
    bm = b.mag * a.den;
    if (a.neg == bn) begin
      r.neg = a.neg;
      r.mag = am + bm;
    end else if (am >= bm) begin
      r.neg = a.neg;
      r.mag = am - bm;
    end else begin
      r.neg = bn;
      r.mag = bm - am;
    end
    if (r.mag == 0) r.neg = 1'b0;
    r.den = a.den * b.den;
    return r;
  endfunction

  function automatic frac_word_t predict_fraction(logic [135:0] d);
    frac_word_t o;
    sm_frac_t a;
    sm_frac_t b;
    sm_frac_t r;
    logic [2:0] op;
    logic uses_rhs;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] lim;
    op = d[2:0];
    a = to_frac(d[34:3], d[66:35]);
    b = to_frac(d[98:67], d[130:99]);
    uses_rhs = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV) ||
               (op == OP_CMP);
    o = '0;
    o.den = 31'd1;
    if (a.den == 0 || (uses_rhs && b.den == 0) || (op == OP_DIV && b.mag == 0)) begin
      o.status = ST_ZDEN;
      return o;
    end
    r = a;
    case (op)
      OP_ADD: r = frac_sum(a, b, 1'b0);
      OP_SUB: r = frac_sum(a, b, 1'b1);
      OP_MUL: begin
        r.neg = a.neg != b.neg;
        r.mag = a.mag * b.mag;
        r.den = a.den * b.den;
      end
      OP_DIV: begin
        r.neg = a.neg != b.neg;
        r.mag = a.mag * b.den;
        r.den = a.den * b.mag;
      end
      OP_NEG: r.neg = !a.neg;
      OP_ABS: r.neg = 1'b0;
      OP_CMP: begin
        r = frac_sum(a, b, 1'b1);
        o.cmp = (r.mag == 0) ? CMP_EQ : (r.neg ? CMP_LT : CMP_GT);
        o.status = ST_OK;
        return o;
      end
      default: ;
    endcase
    if (r.mag == 0) r.neg = 1'b0;
    // Euclid
    x = r.mag;
    y = r.den;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x != 0) begin
      r.mag = r.mag / x;
      r.den = r.den / x;
    end
    lim = 64'd1 << (W - 1);
    if (r.den > lim - 1 || r.mag > (r.neg ? lim : lim - 1)) begin
      o.status = ST_OVF;
      return o;
    end
    t = r.neg ? -r.mag : r.mag;
    o.num = t[31:0];
    o.den = r.den[30:0];
    o.status = ST_OK;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    frac_word_t want;
    frac_word_t got;
    if (rst) begin
      expected_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(predict_fraction(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.num = m_axis_tdata[31:0];
        got.den = m_axis_tdata[62:32];
        got.cmp = m_axis_tdata[64:63];
        got.status = m_axis_tdata[66:65];
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: %h", m_axis_tdata);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== got) begin
            if (want.num !== got.num)
              $error("res_num expected %0d actual %0d", $signed(want.num), $signed(got.num));
            if (want.den !== got.den)
              $error("res_den expected %0d actual %0d", want.den, got.den);
            if (want.cmp !== got.cmp)
              $error("cmp_result expected %0d actual %0d", want.cmp, got.cmp);
            if (want.status !== got.status)
              $error("status expected %0d actual %0d", want.status, got.status);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Top of the rational arithmetic unit testbench: stimulus, stalls and verdict.
module tb;
  import rau_pkg::*;

  localparam int W = 32;
  localparam int STALL_LIMIT = 100000;  // watchdog bound, well above the worst gcd latency
  localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
  localparam logic [31:0] MIN_NEG = 32'h8000_0000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;

  int errors;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  bit watchdog_on;
  int quiet_cycles;

  rational_arithmetic_unit #(.VALUE_WIDTH(W)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  rau_checker #(.W(W)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls per phase; hold_off forces a long stall.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: counts cycles with no word moving on either side.
  always @(posedge clk) begin
    if (!watchdog_on || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one word and hold it until accepted; then maybe go idle a while.
  task automatic send_word(logic [2:0] op, logic [31:0] ln, logic [31:0] ld,
                           logic [31:0] rn, logic [31:0] rd);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, rd, rn, ld, ln, op};
    do @(posedge clk); while (!s_axis_tready);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom, 8'h0};
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Operand mix: mostly small values so the gcd stays short, plus extremes,
  // zero, and a slice of full-width values to toggle every bit.
  function automatic logic [31:0] pick_value(bit is_den);
    int sel;
    sel = $urandom_range(99);
    if (sel < 3) return is_den ? 32'd0 : 32'd0;
    if (sel < 6) return MAX_POS;
    if (sel < 9) return MIN_NEG;
    if (sel < 12) return 32'hffff_ffff;
    if (sel < 15) return 32'd1;
    if (sel < 25) return $urandom;
    if (sel < 35) return $urandom_range(65535) - 32768;
    return $urandom_range(200) - 100;
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_word($urandom_range(7), pick_value(0), pick_value(1), pick_value(0), pick_value(1));
  endtask

  // Stop offering and wait until every accepted word has come back.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    watchdog_on = 1'b1;
    do @(posedge clk); while (pending != 0 || s_axis_tvalid && !s_axis_tready);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    watchdog_on = 1'b0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    watchdog_on = 1'b1;
    @(posedge clk);

    // directed corners
    send_word(OP_NORM, 32'd6, -32'sd4, 32'd0, 32'd0);       // rhs unused, zero den ignored
    send_word(OP_NORM, 32'd0, -32'sd5, 32'd1, 32'd1);       // zero over negative -> 0/1
    send_word(OP_NORM, 32'd3, 32'd0, 32'd1, 32'd1);         // zero lhs denominator
    send_word(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_word(OP_ADD, MIN_NEG, 32'd1, MIN_NEG, 32'd1);      // sum overflows
    send_word(OP_ADD, 32'd1, 32'd1, 32'd1, 32'd0);          // zero rhs denominator
    send_word(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);          // exact zero
    send_word(OP_SUB, MAX_POS, MIN_NEG, MIN_NEG, MAX_POS);
    send_word(OP_MUL, MAX_POS, 32'd1, MAX_POS, 32'd1);      // product overflows
    send_word(OP_MUL, MAX_POS, MIN_NEG, MIN_NEG, MAX_POS);  // reduces to one
    send_word(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd7);          // divide by zero
    send_word(OP_DIV, -32'sd3, 32'd4, 32'd9, -32'sd8);
    send_word(OP_NEG, MIN_NEG, 32'd1, 32'd0, 32'd0);        // negation overflows
    send_word(OP_NEG, MIN_NEG, 32'hffff_ffff, 32'd5, 32'd5);
    send_word(OP_NEG, MAX_POS, 32'hffff_ffff, 32'd5, 32'd5);
    send_word(OP_ABS, MIN_NEG, 32'd1, 32'd0, 32'd0);
    send_word(OP_ABS, -32'sd7, 32'd14, 32'd0, 32'd0);
    send_word(OP_NORM, 32'd2, MIN_NEG, 32'd0, 32'd0);       // den magnitude 2^31 reduces
    send_word(OP_NORM, 32'd1, MIN_NEG, 32'd0, 32'd0);       // den stays 2^31: overflow
    send_word(OP_CMP, 32'd1, 32'd3, 32'd1, 32'd2);          // less
    send_word(OP_CMP, 32'd2, 32'd4, -32'sd1, -32'sd2);      // equal
    send_word(OP_CMP, MAX_POS, 32'd1, MIN_NEG, 32'd1);      // greater
    send_word(OP_CMP, 32'd1, 32'd1, 32'd1, 32'd0);          // zero rhs den
    drain();

    // idling phases
    send_random(400);
    send_idle_pct = 76;
    send_random(300);
    send_idle_pct = 0;
    recv_stall_pct = 76;
    send_random(300);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    send_random(300);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random(20);
    join
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(180);

    drain();
    watchdog_on = 1'b0;
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- rational_arithmetic_unit.f -----
src/rau_pkg.sv
src/rau_ctrl.sv
src/rau_dp.sv
src/rational_arithmetic_unit.sv
tb/sv/rau_checker.sv
tb/sv/tb.sv
